>>> design/kfd_pkg.sv
// shared types and constants for the kiss frame decoder
`timescale 1ns / 1ps

package kfd_pkg;

    // default frame store depth in bytes
    localparam int FRAME_BYTES_DEF = 512;

    // kiss special bytes
    localparam logic [7:0] FEND_CODE  = 8'hC0;
    localparam logic [7:0] FESC_CODE  = 8'hDB;
    localparam logic [7:0] TFEND_CODE = 8'hDC;
    localparam logic [7:0] TFESC_CODE = 8'hDD;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    // gap timeout after reset, in ms
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;

    // action codes carried on the input tuser
    typedef enum logic [1:0] {
        ACT_FEED    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // per-beat status handed from the decoder to the output pipeline
    typedef struct packed {
        logic       done;
        logic       ready;
        logic [3:0] port;
        logic [3:0] command;
        logic [8:0] length;
        logic       overflow;
        logic       rd_en;
    } t_status;

endpackage

>>> design/kfd_frame_store.sv
// frame byte store, one write port and one registered read port
`timescale 1ns / 1ps

module kfd_frame_store
    import kfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int AW          = $clog2(FRAME_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [FRAME_BYTES];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/kfd_decoder.sv
// kiss byte decoder: frame state, timeout check and store addressing
`timescale 1ns / 1ps

module kfd_decoder
    import kfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int AW          = $clog2(FRAME_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_accept,
    input  logic [1:0]    i_action,
    input  logic [7:0]    i_data_byte,
    input  logic [31:0]   i_now_ms,
    input  logic [8:0]    i_read_index,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    output t_status       o_status
);

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int PW = (AW > 10) ? AW : 10;

    logic [CW-1:0] r_wc, n_wc;
    logic          r_inf, n_inf;
    logic          r_esc, n_esc;
    logic          r_open, n_open;
    logic          r_have, n_have;
    logic          r_drop, n_drop;
    logic [31:0]   r_last, n_last;
    logic [7:0]    r_head, n_head;
    logic [15:0]   r_timeout;

    logic [31:0]   w_gap;
    logic          w_tmo;
    logic [7:0]    w_byte;
    logic          w_done;
    logic [CW-1:0] w_len;
    logic [PW-1:0] w_pos;
    t_action       w_act;

    assign w_act = t_action'(i_action);
    assign w_gap = i_now_ms - r_last;
    assign w_tmo = w_gap > {16'd0, r_timeout};

    // next state for one accepted beat
    always_comb begin
        n_wc    = r_wc;
        n_inf   = r_inf;
        n_esc   = r_esc;
        n_open  = r_open;
        n_have  = r_have;
        n_drop  = r_drop;
        n_last  = r_last;
        n_head  = r_head;
        w_byte  = i_data_byte;
        w_done  = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_wc[AW-1:0];
        if (i_accept) begin
            unique case (w_act) inside
                ACT_FEED: begin
                    // long gap restarts the decoder first
                    if (w_tmo) begin
                        n_wc   = '0;
                        n_inf  = 1'b0;
                        n_esc  = 1'b0;
                        n_open = 1'b0;
                        n_have = 1'b0;
                        n_drop = 1'b0;
                    end
                    n_last = i_now_ms;
                    if (i_data_byte == FEND_CODE) begin
                        if (n_inf && n_open) begin
                            n_have = 1'b1;
                            w_done = 1'b1;
                        end else begin
                            if (n_inf) begin
                                n_wc   = '0;
                                n_inf  = 1'b0;
                                n_esc  = 1'b0;
                                n_have = 1'b0;
                                n_drop = 1'b0;
                            end
                            n_open = 1'b1;
                        end
                    end else begin
                        n_inf = 1'b1;
                        if (i_data_byte == FESC_CODE) begin
                            n_esc = 1'b1;
                        end else begin
                            // escape translation, invalid escapes pass as is
                            if (n_esc) begin
                                if (i_data_byte == TFEND_CODE) begin
                                    w_byte = FEND_CODE;
                                end else if (i_data_byte == TFESC_CODE) begin
                                    w_byte = FESC_CODE;
                                end
                            end
                            n_esc = 1'b0;
                            if (n_wc < CW'(FRAME_BYTES)) begin
                                o_we    = 1'b1;
                                o_waddr = n_wc[AW-1:0];
                                if (n_wc == '0) begin
                                    n_head = w_byte;
                                end
                                n_wc = n_wc + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                    end
                end
                ACT_RESTART: begin
                    n_wc   = '0;
                    n_inf  = 1'b0;
                    n_esc  = 1'b0;
                    n_open = 1'b0;
                    n_have = 1'b0;
                    n_drop = 1'b0;
                    n_last = i_now_ms;
                end
                ACT_READ, ACT_NONE: begin
                end
            endcase
        end
    end

    assign o_wdata = w_byte;

    // read addressing and status from the updated state
    assign w_len   = (n_wc == '0) ? '0 : n_wc - CW'(1);
    assign w_pos   = PW'(i_read_index) + PW'(1);
    assign o_raddr = w_pos[AW-1:0];
    assign o_re    = i_accept && (w_act == ACT_READ)
                     && (32'(i_read_index) < 32'(w_len))
                     && (32'(w_pos) < 32'(FRAME_BYTES));

    always_comb begin
        o_status          = '0;
        o_status.done     = w_done;
        o_status.ready    = n_have;
        o_status.port     = (n_wc == '0) ? 4'd0 : 4'((n_head >> 4) & NIBBLE_MASK);
        o_status.command  = (n_wc == '0) ? 4'd0 : 4'(n_head & NIBBLE_MASK);
        o_status.length   = w_len[8:0];
        o_status.overflow = n_drop;
        o_status.rd_en    = o_re;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc   <= '0;
            r_inf  <= 1'b0;
            r_esc  <= 1'b0;
            r_open <= 1'b0;
            r_have <= 1'b0;
            r_drop <= 1'b0;
            r_last <= '0;
        end else begin
            r_wc   <= n_wc;
            r_inf  <= n_inf;
            r_esc  <= n_esc;
            r_open <= n_open;
            r_have <= n_have;
            r_drop <= n_drop;
            r_last <= n_last;
        end
    end

    // header byte copy, only meaningful while the count is non-zero
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= GAP_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    // a beat either writes or reads the store, never both
    a_no_rw_same_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("store written and read in one beat");

    // overflow only once the store is full
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_wc == CW'(FRAME_BYTES)))
        else $error("overflow flag with room left");

    // a held frame was opened and has started
    a_have_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_inf && r_open))
        else $error("frame held outside an opened frame");

endmodule

>>> design/kiss_frame_decoder_core.sv
// kiss frame decoder top level: stream channels, store and output pipeline
`timescale 1ns / 1ps
//
// KISS receive decoder. Input beats on s_axis carry an action in tuser
// (feed byte, read frame byte, restart) and data byte, ms timestamp and read
// index in tdata. Every accepted beat yields exactly one output beat on m_axis:
// tlast flags a closing FEND that completed a frame, tdata holds the frame
// status and, for a read, the payload byte at the requested index.
// The gap timeout is written over the cfg channel, which is always ready; write
// it only while no beat is in flight.
// An accepted beat passes the read stage (decoder update and registered store
// read) and then the output register before output valid.
// Throughput is one beat per cycle while m_axis does not stall; the decoder
// state updates on each accepted beat and the store takes at most one write or one read per beat.
// Reset clears the decoder state, sets the timeout to 100 ms and empties the
// pipeline; store contents need no clearing.
// When m_axis stalls, up to two beats are held (read stage and output
// register) before s_axis_tready drops.
//

module kiss_frame_decoder_core
    import kfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write, gap timeout in ms
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [39:8] now_ms, [48:40] read_index, [55:49] zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] frame_ready, [4:1] port, [8:5] command, [17:9] payload_length,
    // [25:18] read_data, [26] overflow, [31:27] zero
    output logic [31:0] m_axis_tdata,
    // frame_done
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(FRAME_BYTES);

    logic          w_accept;
    logic          w_advance;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    t_status       w_status;

    logic          r_s1_v;
    t_status       r_s1_st;
    logic          r_out_v;
    logic [31:0]   r_out_data;
    logic          r_out_last;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_s1_v || !r_out_v || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_advance     = r_s1_v && (!r_out_v || m_axis_tready);

    kfd_decoder #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_action     (s_axis_tuser),
        .i_data_byte  (s_axis_tdata[7:0]),
        .i_now_ms     (s_axis_tdata[39:8]),
        .i_read_index (s_axis_tdata[48:40]),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .o_status     (w_status)
    );

    kfd_frame_store #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // read stage valid, waits for the store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_accept) begin
            r_s1_v <= 1'b1;
        end else if (w_advance) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_st <= w_status;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_advance) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    // output beat assembly
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_last <= r_s1_st.done;
            r_out_data <= {5'd0,
                           r_s1_st.overflow,
                           r_s1_st.rd_en ? w_rdata : 8'd0,
                           r_s1_st.length,
                           r_s1_st.command,
                           r_s1_st.port,
                           r_s1_st.ready};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // both stages full and stalled blocks the input
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_out_v && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken with pipeline full");

    // an accepted beat occupies the read stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_v)
        else $error("accepted beat lost");

    // a completed frame is always reported as held
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[0])
        else $error("frame done without frame ready");

endmodule

>>> tb/tb_kiss_frame_decoder_core.sv
// testbench for the kiss frame decoder core: stream stimulus, bit-true prediction, checks
`timescale 1ns / 1ps

module tb_kiss_frame_decoder_core;
    import kfd_pkg::*;

    localparam int FRAME_BYTES = FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 400;

    // one input beat before packing
    typedef struct packed {
        t_action     action;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
        logic [8:0]  read_index;
    } t_kiss_beat;

    // one output beat after unpacking
    typedef struct packed {
        logic       frame_done;
        logic       frame_ready;
        logic [3:0] port;
        logic [3:0] command;
        logic [8:0] payload_length;
        logic [7:0] read_data;
        logic       overflow;
    } t_frame_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    kiss_frame_decoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // decoder state as predicted
    logic [7:0]  model_store [FRAME_BYTES];
    int unsigned model_count;
    bit          model_in_frame;
    bit          model_in_escape;
    bit          model_saw_open;
    bit          model_have_frame;
    bit          model_dropped;
    logic [31:0] model_last_ms;
    logic [15:0] model_timeout;

    // stimulus and scoreboard storage
    t_kiss_beat    pending_beats[$];
    t_frame_status expected_status[$];
    t_kiss_beat    tx_beat;
    logic [31:0]   gen_ms;
    int unsigned   queued_count;
    int unsigned   result_count;
    int unsigned   mismatches;
    int unsigned   cycle_count;
    int unsigned   stall_requests;
    int unsigned   stall_served;
    int unsigned   rx_hold;
    int unsigned   rx_wait;
    int unsigned   tx_wait;
    bit            tx_busy;
    bit            tx_calm;
    bit            rx_calm;
    bit            in_fire;
    bit            out_fire;

    // decoder restart: store contents survive
    function automatic void restart_model(logic [31:0] now_ms);
        model_count      = 0;
        model_in_frame   = 1'b0;
        model_in_escape  = 1'b0;
        model_saw_open   = 1'b0;
        model_have_frame = 1'b0;
        model_dropped    = 1'b0;
        model_last_ms    = now_ms;
    endfunction

    // apply one beat to the predicted state and return the status it reports
    function automatic t_frame_status decode_step(t_kiss_beat b);
        t_frame_status r;
        logic [7:0]    c;
        int unsigned   plen;
        r = '0;
        case (b.action)
            ACT_FEED: begin
                c = b.data_byte;
                if (b.now_ms - model_last_ms > {16'd0, model_timeout})
                    restart_model(b.now_ms);
                model_last_ms = b.now_ms;
                if (c == FEND_CODE) begin
                    if (model_in_frame && model_saw_open) begin
                        model_have_frame = 1'b1;
                        r.frame_done = 1'b1;
                    end else begin
                        // fend inside a frame that never opened restarts first
                        if (model_in_frame)
                            restart_model(b.now_ms);
                        model_saw_open = 1'b1;
                    end
                end else begin
                    model_in_frame = 1'b1;
                    if (c == FESC_CODE) begin
                        model_in_escape = 1'b1;
                    end else begin
                        // invalid escapes pass the byte through unchanged
                        if (model_in_escape) begin
                            if (c == TFEND_CODE)
                                c = FEND_CODE;
                            else if (c == TFESC_CODE)
                                c = FESC_CODE;
                            model_in_escape = 1'b0;
                        end
                        if (model_count < FRAME_BYTES) begin
                            model_store[model_count] = c;
                            model_count++;
                        end else begin
                            model_dropped = 1'b1;
                        end
                    end
                end
            end
            ACT_RESTART: restart_model(b.now_ms);
            default: ;
        endcase
        plen = (model_count == 0) ? 0 : model_count - 1;
        if (b.action == ACT_READ && b.read_index < plen)
            r.read_data = model_store[b.read_index + 1];
        if (model_count != 0) begin
            r.port    = model_store[0][7:4];
            r.command = model_store[0][3:0];
        end
        r.frame_ready    = model_have_frame;
        r.payload_length = plen[8:0];
        r.overflow       = model_dropped;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("beat %0d %s mismatch: expected %0d, got %0d",
                         result_count, name, want, got);
        end
    endfunction

    function automatic int unsigned idle_cycles(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // prediction on input beats, checking on output beats, run limit
    always @(posedge i_clk) begin : result_check
        t_frame_status got;
        t_frame_status want;
        cycle_count++;
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire)
            expected_status.push_back(decode_step(tx_beat));
        if (out_fire) begin
            got.frame_done     = m_axis_tlast;
            got.frame_ready    = m_axis_tdata[0];
            got.port           = m_axis_tdata[4:1];
            got.command        = m_axis_tdata[8:5];
            got.payload_length = m_axis_tdata[17:9];
            got.read_data      = m_axis_tdata[25:18];
            got.overflow       = m_axis_tdata[26];
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d arrived with nothing outstanding", result_count);
            end else begin
                want = expected_status.pop_front();
                compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
                compare_field("frame_ready", 32'(want.frame_ready), 32'(got.frame_ready));
                compare_field("port", 32'(want.port), 32'(got.port));
                compare_field("command", 32'(want.command), 32'(got.command));
                compare_field("payload_length", 32'(want.payload_length),
                              32'(got.payload_length));
                compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
                compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
            end
            result_count++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // input driver, random gaps between beats
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                tx_busy = 1'b0;
                tx_wait = idle_cycles(tx_calm);
                if ($urandom_range(0, 31) == 0)
                    tx_calm = !tx_calm;
            end
            if (!tx_busy) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                end else if (pending_beats.size() != 0) begin
                    tx_beat = pending_beats.pop_front();
                    tx_busy = 1'b1;
                end
            end
            s_axis_tvalid <= tx_busy;
            s_axis_tdata  <= {7'd0, tx_beat.read_index, tx_beat.now_ms, tx_beat.data_byte};
            s_axis_tuser  <= tx_beat.action;
        end
    end

    // output back-pressure, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                rx_wait = idle_cycles(rx_calm);
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            if (rx_hold != 0) begin
                rx_hold--;
            end else if (stall_requests != stall_served) begin
                stall_served = stall_requests;
                rx_hold = LONG_HOLD;
            end
            m_axis_tready <= (rx_hold == 0) && (rx_wait == 0);
        end
    end

    task automatic queue_beat(t_action a, logic [7:0] d, logic [31:0] now_ms,
                              logic [8:0] idx);
        t_kiss_beat b;
        b.action     = a;
        b.data_byte  = d;
        b.now_ms     = now_ms;
        b.read_index = idx;
        pending_beats.push_back(b);
        queued_count++;
    endtask

    task automatic feed_after(logic [7:0] d, int unsigned delta);
        gen_ms = gen_ms + delta;
        queue_beat(ACT_FEED, d, gen_ms, 9'($urandom_range(0, 510)));
    endtask

    // feed within the gap timeout, now and then right on it
    task automatic feed(logic [7:0] d);
        int unsigned cap;
        cap = (model_timeout < 16'd12) ? 32'(model_timeout) : 12;
        if ($urandom_range(0, 19) == 0)
            feed_after(d, 32'(model_timeout));
        else
            feed_after(d, $urandom_range(0, cap));
    endtask

    // feed with a gap beyond the timeout
    task automatic feed_late(logic [7:0] d);
        feed_after(d, 32'(model_timeout) + 1 + $urandom_range(0, 500));
    endtask

    task automatic feed_escaped(logic [7:0] d);
        if (d == FEND_CODE) begin
            feed(FESC_CODE);
            feed(TFEND_CODE);
        end else if (d == FESC_CODE) begin
            feed(FESC_CODE);
            feed(TFESC_CODE);
        end else begin
            feed(d);
        end
    endtask

    task automatic read_at(logic [8:0] idx);
        queue_beat(ACT_READ, 8'($urandom), $urandom, idx);
    endtask

    task automatic restart_at(logic [31:0] now_ms);
        gen_ms = now_ms;
        queue_beat(ACT_RESTART, 8'($urandom), now_ms, 9'($urandom_range(0, 510)));
    endtask

    // byte values biased towards the kiss special codes
    function automatic logic [7:0] frame_byte();
        logic [7:0] specials [4];
        specials = '{FEND_CODE, FESC_CODE, TFEND_CODE, TFESC_CODE};
        if ($urandom_range(0, 7) == 0)
            return specials[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_frame(int plen, bit closed);
        feed(FEND_CODE);
        feed_escaped(8'($urandom_range(0, 255)));
        repeat (plen) feed_escaped(frame_byte());
        if (closed)
            feed(FEND_CODE);
    endtask

    task automatic read_payload(int n, int plen);
        int unsigned top;
        top = (plen + 1 > 510) ? 510 : plen + 1;
        repeat (n) begin
            if ($urandom_range(0, 3) != 0)
                read_at(9'($urandom_range(0, top)));
            else
                read_at(9'($urandom_range(0, 510)));
        end
    endtask

    function automatic int frame_length();
        return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : $urandom_range(13, 60);
    endfunction

    // mostly well-formed frames with reads, the rest noise and broken frames
    task automatic random_traffic(int unsigned n);
        int unsigned start;
        int unsigned pick;
        int          plen;
        start = queued_count;
        while (queued_count - start < n) begin
            pick = $urandom_range(0, 99);
            plen = frame_length();
            if (pick < 60) begin
                send_frame(plen, 1'b1);
                read_payload($urandom_range(1, 4), plen);
                // bytes after a completed frame join it, the next fend completes again
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 3)) feed_escaped(frame_byte());
                    feed(FEND_CODE);
                    read_payload(2, plen + 3);
                end
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 8)) feed(frame_byte());
            end else if (pick < 76) begin
                restart_at($urandom);
            end else if (pick < 82) begin
                feed_late(frame_byte());
            end else if (pick < 88) begin
                if ($urandom_range(0, 1) != 0)
                    queue_beat(ACT_NONE, 8'($urandom), $urandom,
                               9'($urandom_range(0, 510)));
                else
                    read_at(9'($urandom_range(0, 510)));
            end else if (pick < 94) begin
                // frame with no opening fend, closed by a fend that restarts
                restart_at($urandom);
                repeat ($urandom_range(1, 4)) feed_escaped(frame_byte());
                feed(FEND_CODE);
                repeat (plen) feed_escaped(frame_byte());
                feed(FEND_CODE);
                read_payload(2, plen);
            end else begin
                // frame cut short by a timeout
                send_frame(plen, 1'b0);
                feed_late(FEND_CODE);
                send_frame(frame_length(), 1'b1);
                read_payload(2, plen);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || tx_busy || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_gap_timeout(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        model_timeout = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        model_timeout = GAP_TIMEOUT_RST;
        model_last_ms = '0;
        restart_model('0);
        gen_ms = '0;
        tx_beat = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: escapes, invalid and double escape, repeated fend, reads
        feed(FEND_CODE);
        feed(8'h5A);
        feed(FESC_CODE);
        feed(TFEND_CODE);
        feed(FESC_CODE);
        feed(TFESC_CODE);
        feed(FESC_CODE);
        feed(FESC_CODE);
        feed(8'h00);
        feed(FESC_CODE);
        feed(8'hFF);
        feed(FEND_CODE);
        feed(FEND_CODE);
        read_at(9'd0);
        read_at(9'd3);
        read_at(9'd510);
        queue_beat(ACT_NONE, 8'hFF, 32'hFFFF_FFFF, 9'h1FF);
        feed(8'h12);
        read_at(9'd4);
        // timestamp wrap, then a fend in a frame that never opened
        restart_at(32'hFFFF_FFF0);
        feed_after(8'h77, 16);
        feed(FEND_CODE);
        feed(FEND_CODE);
        feed_after(8'h33, 32'(model_timeout));
        feed_after(8'h44, 32'(model_timeout) + 1);
        wait_idle();

        // zero timeout, with the long output hold-off
        write_gap_timeout(16'd0);
        random_traffic(40);
        stall_requests++;
        wait_idle();

        // largest timeout, one frame past the store size
        write_gap_timeout(16'hFFFF);
        send_frame(FRAME_BYTES + 3, 1'b1);
        read_at(9'd510);
        read_at(9'd509);
        read_payload(4, FRAME_BYTES);
        feed(8'hA5);
        feed(FEND_CODE);
        read_at(9'd510);
        random_traffic(20);
        wait_idle();

        write_gap_timeout(16'd1);
        random_traffic(20);
        wait_idle();

        write_gap_timeout(16'($urandom_range(2, 65534)));
        random_traffic(20);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> kiss_frame_decoder_core.f
design/kfd_pkg.sv
design/kfd_frame_store.sv
design/kfd_decoder.sv
design/kiss_frame_decoder_core.sv
tb/tb_kiss_frame_decoder_core.sv
